/* hdl/hotp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HOTP package
// Shared types, constants and helper functions for the HOTP generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

  localparam int MaxKeyBytes = 32;
  localparam int KeyLenW     = 6;
  localparam int DigitW      = 4;
  localparam int OtpW        = 30;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_KEYLEN = 3'd4;
  localparam logic [2:0] REG_DIGITS = 3'd5;

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INNER_PAD,
    ST_INNER_MSG,
    ST_OUTER_PAD,
    ST_OUTER_MSG,
    ST_TRUNC,
    ST_MOD,
    ST_OUT
  } hotp_state_t;

  // Command from the sequencer to the SHA-1 compression unit.
  typedef struct packed {
    logic       start;
    logic       init;    // begin from the standard initial hash value
  } sha_cmd_t;

  // Round constant for a given round number.
  function automatic logic [31:0] sha_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = 32'h5A827999;
    else if (rnd < 7'd40) k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) k = 32'h8F1BBCDC;
    else                  k = 32'hCA62C1D6;
    return k;
  endfunction

  // Modulus ten to the digit count, clamped to six through nine digits.
  function automatic logic [OtpW-1:0] pow10(input logic [DigitW-1:0] dc);
    logic [OtpW-1:0] m;
    if (dc <= 4'd6)      m = 30'd1000000;
    else if (dc == 4'd7) m = 30'd10000000;
    else if (dc == 4'd8) m = 30'd100000000;
    else                 m = 30'd1000000000;
    return m;
  endfunction

endpackage

/* hdl/hotp_sha1.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HOTP SHA-1 compression unit
// One 512-bit block per run, one round per cycle through a single round
// datapath, with the message schedule in a 16-word shift window.
// ----------------------------------------------------------------------------
module hotp_sha1 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hotp_pkg::sha_cmd_t    cmd,
  input  logic [511:0]          block,
  output logic                  done,
  output logic [159:0]          digest
);

  logic [511:0] w_r, w_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [159:0] h_r, h_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  f, wt, wnew, t;
  logic [159:0] h_base;

  // Round function on the current working variables.
  always_comb begin
    wt   = w_r[511:480];
    wnew = w_r[95:64] ^ w_r[255:224] ^ w_r[447:416] ^ w_r[511:480];
    wnew = {wnew[30:0], wnew[31]};
    if (rnd_r < 7'd20)      f = (b_r & c_r) | (~b_r & d_r);
    else if (rnd_r < 7'd40) f = b_r ^ c_r ^ d_r;
    else if (rnd_r < 7'd60) f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    else                    f = b_r ^ c_r ^ d_r;
    t = {a_r[26:0], a_r[31:27]} + f + e_r + hotp_pkg::sha_k(rnd_r) + wt;
  end

  // Sequencing of start, rounds and final add.
  always_comb begin
    h_base   = cmd.init ? 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0 : h_r;
    w_nxt    = w_r;
    a_nxt    = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    h_nxt    = h_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      w_nxt    = block;
      h_nxt    = h_base;
      {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt} = h_base;
      rnd_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      w_nxt = {w_r[479:0], wnew};
      a_nxt = t; b_nxt = a_r; c_nxt = {b_r[1:0], b_r[31:2]}; d_nxt = c_r; e_nxt = d_r;
      rnd_nxt = rnd_r + 7'd1;
      if (rnd_r == 7'd79) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        h_nxt = {h_r[159:128] + t, h_r[127:96] + a_r,
                 h_r[95:64] + {b_r[1:0], b_r[31:2]}, h_r[63:32] + c_r, h_r[31:0] + d_r};
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    h_r <= h_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt;
  end

  assign done   = done_r;
  assign digest = h_r;

  // The round counter stays within the 80 rounds while busy.
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rnd_r < 7'd80)
    else $error("round counter overrun");
  // Done follows the last round.
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("done while busy");
  // A start is not issued while a block is in progress.
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !cmd.start)
    else $error("start while busy");

endmodule

/* hdl/hotp_code_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HOTP code generator core
// HMAC-SHA-1 one-time code with dynamic truncation and decimal reduction.
// ----------------------------------------------------------------------------
// Usage: the key, key length and digit count are written on the cfg_ port
// while the block is idle. Each in_ beat carries a 64-bit counter; the block
// hashes it under HMAC-SHA-1 and returns one out_ beat with the code.
// Steps from in_ beat to out_ beat: four SHA-1 compressions on one shared
// round unit (inner pad, inner message, outer pad, outer message), dynamic
// truncation, then restoring-subtract reduction. in_tready is high only
// when idle, so a new counter is taken only after the last code is taken.
// Reset: synchronous, active low; key words clear to zero, key length is 20
// and digit count is 6.
// Stall: the result is held in out_tdata until out_tready; the next input is
// taken no earlier than the cycle after the result is taken.
// ----------------------------------------------------------------------------
module hotp_code_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [63:0] moving_factor
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [29:0] otp_value, [31:30] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  hotp_pkg::hotp_state_t state_r, state_nxt;
  logic [255:0] key_r;
  logic [5:0]   klen_r;
  logic [3:0]   dig_r;
  logic [63:0]  msg_r, msg_nxt;
  logic [159:0] inner_r, inner_nxt;
  logic [31:0]  dbc_r, dbc_nxt;
  logic [59:0]  div_r, div_nxt;       // modulus shifted for restoring reduction
  logic [4:0]   cnt_r, cnt_nxt;
  logic [29:0]  otp_r, otp_nxt;
  hotp_pkg::sha_cmd_t cmd;
  logic         sha_done;
  logic [159:0] digest;
  logic [511:0] block, keyblk;
  logic [5:0]   elen;
  logic [7:0]   pad;
  logic [3:0]   off;
  logic [31:0]  word_at;
  logic [60:0]  rem_ext;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      klen_r <= 6'd20;
      dig_r  <= 4'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        hotp_pkg::REG_KEY0:   key_r[255:192] <= cfg_wdata;
        hotp_pkg::REG_KEY1:   key_r[191:128] <= cfg_wdata;
        hotp_pkg::REG_KEY2:   key_r[127:64]  <= cfg_wdata;
        hotp_pkg::REG_KEY3:   key_r[63:0]    <= cfg_wdata;
        hotp_pkg::REG_KEYLEN: klen_r <= cfg_wdata[5:0];
        hotp_pkg::REG_DIGITS: dig_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Padded key block: bytes beyond the effective length hold the pad byte alone.
  always_comb begin
    elen = (klen_r > 6'd32) ? 6'd32 : klen_r;
    pad  = (state_r == hotp_pkg::ST_IDLE) ? 8'h36 : 8'h5C;
    for (int i = 0; i < 64; i++) begin
      if (i < 32 && 6'(i) < elen) keyblk[511-8*i -: 8] = key_r[255-8*i -: 8] ^ pad;
      else                         keyblk[511-8*i -: 8] = pad;
    end
  end

  // Block fed to the compression unit.
  always_comb begin
    case (state_r)
      hotp_pkg::ST_INNER_PAD: block = {msg_r, 8'h80, 376'd0, 64'd576};
      hotp_pkg::ST_OUTER_PAD: block = {inner_r, 8'h80, 280'd0, 64'd672};
      default:                block = keyblk;
    endcase
  end

  // Dynamic truncation window; the subtract keeps one extra bit for the sign.
  always_comb begin
    off     = digest[3:0];
    word_at = 32'(digest >> (8'd128 - {off, 3'b000}));
    rem_ext = {29'd0, dbc_r} - {1'b0, div_r};
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    msg_nxt   = msg_r;
    inner_nxt = inner_r;
    dbc_nxt   = dbc_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    otp_nxt   = otp_r;
    cmd       = '0;
    case (state_r)
      hotp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          msg_nxt   = in_tdata;
          cmd.start = 1'b1;
          cmd.init  = 1'b1;
          state_nxt = hotp_pkg::ST_INNER_PAD;
        end
      end
      hotp_pkg::ST_INNER_PAD: begin
        if (sha_done) begin
          cmd.start = 1'b1;
          state_nxt = hotp_pkg::ST_INNER_MSG;
        end
      end
      hotp_pkg::ST_INNER_MSG: begin
        if (sha_done) begin
          inner_nxt = digest;
          cmd.start = 1'b1;
          cmd.init  = 1'b1;
          state_nxt = hotp_pkg::ST_OUTER_PAD;
        end
      end
      hotp_pkg::ST_OUTER_PAD: begin
        if (sha_done) begin
          cmd.start = 1'b1;
          state_nxt = hotp_pkg::ST_OUTER_MSG;
        end
      end
      hotp_pkg::ST_OUTER_MSG: begin
        if (sha_done) state_nxt = hotp_pkg::ST_TRUNC;
      end
      hotp_pkg::ST_TRUNC: begin
        dbc_nxt   = {1'b0, word_at[30:0]};
        div_nxt   = {hotp_pkg::pow10(dig_r), 30'd0};
        cnt_nxt   = 5'd30;
        state_nxt = hotp_pkg::ST_MOD;
      end
      hotp_pkg::ST_MOD: begin
        // One restoring subtract step per cycle.
        if (!rem_ext[60]) dbc_nxt = rem_ext[31:0];
        div_nxt = div_r >> 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          otp_nxt   = (!rem_ext[60]) ? rem_ext[29:0] : dbc_r[29:0];
          state_nxt = hotp_pkg::ST_OUT;
        end
      end
      hotp_pkg::ST_OUT: begin
        if (out_tready) state_nxt = hotp_pkg::ST_IDLE;
      end
      default: state_nxt = hotp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hotp_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r   <= msg_nxt;
    inner_r <= inner_nxt;
    dbc_r   <= dbc_nxt;
    div_r   <= div_nxt;
    otp_r   <= otp_nxt;
  end

  hotp_sha1 u_sha1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .block  (block),
    .done   (sha_done),
    .digest (digest)
  );

  assign in_tready  = (state_r == hotp_pkg::ST_IDLE);
  assign out_tvalid = (state_r == hotp_pkg::ST_OUT);
  assign out_tdata  = {2'b00, otp_r};

  // The code is always below the largest modulus.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> otp_r < 30'd1000000000) else $error("code out of range");
  // A stalled result does not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(otp_r)) else $error("result changed");
  // Input and output are never both offered by the block.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");

endmodule
